@@ src/nfc_host_frame_builder_core_macros.svh @@
// Shared assertion macros; clocked on clk, quiet while rst_n is low.
`ifndef NFC_HOST_FRAME_BUILDER_CORE_MACROS_SVH
`define NFC_HOST_FRAME_BUILDER_CORE_MACROS_SVH

`define NHFB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define NHFB_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ src/nhfb_pkg.sv @@
`timescale 1ns / 1ps

package nhfb_pkg;

    localparam logic [7:0] SPI_WRITE_BYTE = 8'h01;

    localparam logic [7:0] RST_PREAMBLE  = 8'h00;
    localparam logic [7:0] RST_START_1ST = 8'h00;
    localparam logic [7:0] RST_START_2ND = 8'hFF;
    localparam logic [7:0] RST_FRAME_ID  = 8'hD4;
    localparam logic [7:0] RST_POSTAMBLE = 8'h00;

    typedef enum logic [2:0] {
        REG_PREAMBLE  = 3'd0,
        REG_START_1ST = 3'd1,
        REG_START_2ND = 3'd2,
        REG_FRAME_ID  = 3'd3,
        REG_POSTAMBLE = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_SPI  = 4'd0,
        ST_PRE  = 4'd1,
        ST_SC1  = 4'd2,
        ST_SC2  = 4'd3,
        ST_LEN  = 4'd4,
        ST_LCS  = 4'd5,
        ST_TFI  = 4'd6,
        ST_CMD  = 4'd7,
        ST_DCS  = 4'd8,
        ST_POST = 4'd9
    } step_t;

    typedef struct packed {
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] dcs;
        logic       first;
        logic       last;
    } frame_rec_t;

    typedef struct packed {
        logic [7:0] preamble;
        logic [7:0] start_first;
        logic [7:0] start_second;
        logic [7:0] frame_id;
        logic [7:0] postamble;
    } cfg_t;

endpackage

@@ src/nfc_host_frame_builder_core.sv @@
`timescale 1ns / 1ps
// Host-to-reader information frame builder.
// Command bytes enter on a queue-style channel (push/full) with frame_len,
// is_first and is_last; frame bytes leave on a queue-style channel
// (empty/pop) as out_byte with frame_end on the postamble and run_last on
// the last byte caused by each input transaction.
// A first byte yields ten bytes with is_last (0x01, preamble, start codes,
// LEN, LCS, TFI, command, DCS, postamble), eight without; a middle byte
// yields one, a last byte three. A byte outside a frame is dropped.
// The first byte of a transaction passes the record queue and the output
// register. Throughput: one frame byte per cycle from the sequencer while
// out_byte is popped; input transactions are taken one per cycle until the
// QUEUE_DEPTH-entry record queue between front and sequencer fills.
// A stalled receiver holds the current byte; the queue then fills and full
// rises. Reset restores the register defaults, closes any open frame and
// empties the queue and output stage. Registers sit on the APB port at
// byte offsets 0x00 to 0x10; write them only while the block is idle.
module nfc_host_frame_builder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  cmd_byte,
    input  logic [7:0]  frame_len,
    input  logic        is_first,
    input  logic        is_last,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        frame_end,
    output logic        run_last
);
    import nhfb_pkg::*;

    cfg_t       cfg_reg;
    frame_rec_t q_wr_data, q_rd_data;
    logic       q_wr, q_rd, q_full, q_empty;
    logic       cfg_wr;
    reg_idx_t   reg_idx;
    logic [7:0] rd_val;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign full    = q_full;
    assign prdata  = {24'd0, rd_val};

    always_comb
    begin
        case (reg_idx)
            REG_PREAMBLE:  rd_val = cfg_reg.preamble;
            REG_START_1ST: rd_val = cfg_reg.start_first;
            REG_START_2ND: rd_val = cfg_reg.start_second;
            REG_FRAME_ID:  rd_val = cfg_reg.frame_id;
            REG_POSTAMBLE: rd_val = cfg_reg.postamble;
            default:       rd_val = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preamble     <= RST_PREAMBLE;
            cfg_reg.start_first  <= RST_START_1ST;
            cfg_reg.start_second <= RST_START_2ND;
            cfg_reg.frame_id     <= RST_FRAME_ID;
            cfg_reg.postamble    <= RST_POSTAMBLE;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_PREAMBLE:  cfg_reg.preamble     <= pwdata[7:0];
                REG_START_1ST: cfg_reg.start_first  <= pwdata[7:0];
                REG_START_2ND: cfg_reg.start_second <= pwdata[7:0];
                REG_FRAME_ID:  cfg_reg.frame_id     <= pwdata[7:0];
                REG_POSTAMBLE: cfg_reg.postamble    <= pwdata[7:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    nhfb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .cmd_byte  (cmd_byte),
        .frame_len (frame_len),
        .is_first  (is_first),
        .is_last   (is_last),
        .frame_id  (cfg_reg.frame_id),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .q_wr_data (q_wr_data)
    );

    nhfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    nhfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_rd_data (q_rd_data),
        .q_rd      (q_rd),
        .pop       (pop),
        .empty     (empty),
        .out_byte  (out_byte),
        .frame_end (frame_end),
        .run_last  (run_last)
    );

endmodule

@@ src/nhfb_queue.sv @@
`timescale 1ns / 1ps

module nhfb_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  nhfb_pkg::frame_rec_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output nhfb_pkg::frame_rec_t rd_data,
    output logic                empty
);
    import nhfb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    frame_rec_t      mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_wr, do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ src/nhfb_front.sv @@
`timescale 1ns / 1ps

module nhfb_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [7:0]           cmd_byte,
    input  logic [7:0]           frame_len,
    input  logic                 is_first,
    input  logic                 is_last,
    input  logic [7:0]           frame_id,
    input  logic                 q_full,
    output logic                 q_wr,
    output nhfb_pkg::frame_rec_t q_wr_data
);
    import nhfb_pkg::*;

    logic [7:0] data_sum_reg, data_sum_next;
    logic       in_frame_reg, in_frame_next;
    logic [7:0] sum_base;

    always_comb
    begin
        q_wr            = push && !q_full && (is_first || in_frame_reg);
        sum_base        = is_first ? frame_id : data_sum_reg;
        data_sum_next   = sum_base + cmd_byte;
        in_frame_next   = !is_last;
        q_wr_data.cmd   = cmd_byte;
        q_wr_data.len   = frame_len + 8'd1;
        q_wr_data.dcs   = 8'd0 - data_sum_next;
        q_wr_data.first = is_first;
        q_wr_data.last  = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_sum_reg <= '0;
            in_frame_reg <= 1'b0;
        end
        else if (q_wr)
        begin
            data_sum_reg <= data_sum_next;
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

@@ src/nhfb_back.sv @@
`timescale 1ns / 1ps
`include "nfc_host_frame_builder_core_macros.svh"

module nhfb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nhfb_pkg::cfg_t       cfg,
    input  logic                 q_empty,
    input  nhfb_pkg::frame_rec_t q_rd_data,
    output logic                 q_rd,
    input  logic                 pop,
    output logic                 empty,
    output logic [7:0]           out_byte,
    output logic                 frame_end,
    output logic                 run_last
);
    import nhfb_pkg::*;

    step_t      step_reg, step_next, cur_step;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       frame_end_reg, frame_end_next;
    logic       run_last_reg, run_last_next;
    logic       out_free, load, last_step;

    assign empty     = !out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;
    assign run_last  = run_last_reg;

    always_comb
    begin
        out_free       = !out_valid_reg || pop;
        load           = !q_empty && out_free;
        cur_step       = (step_reg == ST_SPI && !q_rd_data.first) ? ST_CMD : step_reg;
        last_step      = (cur_step == ST_POST) || (cur_step == ST_CMD && !q_rd_data.last);
        step_next      = step_reg;
        out_byte_next  = out_byte_reg;
        frame_end_next = frame_end_reg;
        run_last_next  = run_last_reg;
        out_valid_next = out_valid_reg && !pop;
        q_rd           = load && last_step;
        case (cur_step)
            ST_SPI:  out_byte_next = SPI_WRITE_BYTE;
            ST_PRE:  out_byte_next = cfg.preamble;
            ST_SC1:  out_byte_next = cfg.start_first;
            ST_SC2:  out_byte_next = cfg.start_second;
            ST_LEN:  out_byte_next = q_rd_data.len;
            ST_LCS:  out_byte_next = 8'd0 - q_rd_data.len;
            ST_TFI:  out_byte_next = cfg.frame_id;
            ST_CMD:  out_byte_next = q_rd_data.cmd;
            ST_DCS:  out_byte_next = q_rd_data.dcs;
            ST_POST: out_byte_next = cfg.postamble;
            default: out_byte_next = SPI_WRITE_BYTE;
        endcase
        case (cur_step)
            ST_SPI:  step_next = ST_PRE;
            ST_PRE:  step_next = ST_SC1;
            ST_SC1:  step_next = ST_SC2;
            ST_SC2:  step_next = ST_LEN;
            ST_LEN:  step_next = ST_LCS;
            ST_LCS:  step_next = ST_TFI;
            ST_TFI:  step_next = ST_CMD;
            ST_CMD:  step_next = q_rd_data.last ? ST_DCS : ST_SPI;
            ST_DCS:  step_next = ST_POST;
            ST_POST: step_next = ST_SPI;
            default: step_next = ST_SPI;
        endcase
        frame_end_next = (cur_step == ST_POST);
        run_last_next  = last_step;
        if (!load)
        begin
            step_next      = step_reg;
            out_byte_next  = out_byte_reg;
            frame_end_next = frame_end_reg;
            run_last_next  = run_last_reg;
        end
        else
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_SPI;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        frame_end_reg <= frame_end_next;
        run_last_reg  <= run_last_next;
    end

    `NHFB_ASSERT(a_end_is_run_last, out_valid_reg && frame_end_reg |-> run_last_reg, "postamble not last of run")
    `NHFB_ASSERT(a_pop_restarts, q_rd |=> step_reg == ST_SPI, "sequencer not rewound after record")
    `NHFB_ASSERT_NEVER(a_pop_without_load, q_rd && !load, "record dropped without output")

endmodule
